// ----- rtl/alrr_pkg.sv -----
// Package for the additive lagged random range unit: constants, state and command types.
// No dependencies; used by every module of the block.
`default_nettype none
package alrr_pkg;
   localparam int unsigned RING_SIZE    = 56;
   localparam logic [5:0]  LAG_START    = 6'd31;
   localparam logic [5:0]  WRITE_START  = 6'd55;
   localparam logic [31:0] WORD_MAX     = 32'hFFFF_FFFF;
   localparam logic [31:0] SEED_ADD     = 32'd257;
   localparam logic [15:0] WARMUP_DRAWS = 16'd10000;
   localparam logic [15:0] RETRY_LIMIT  = 16'd10000;

   localparam logic        CMD_DRAW   = 1'b0;
   localparam logic        CMD_RESEED = 1'b1;

   localparam logic [1:0]  ST_OK      = 2'd0;
   localparam logic [1:0]  ST_RETRY   = 2'd1;
   localparam logic [1:0]  ST_NOINIT  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_DIV_LIM, S_DIV_LIM_RUN, S_LIMIT, S_FILL, S_READ, S_STEP, S_DIV_Q,
      S_DIV_Q_RUN, S_DONE
   } state_type;

   typedef struct packed {
      logic load_req;     // capture command and size
      logic start_lim;    // start divider on WORD_MAX / size
      logic calc_limit;   // limit = size*divisor - 1, or WORD_MAX for size <= 1
      logic fill_init;    // start ring fill from seed
      logic fill_step;    // write one ring entry
      logic reset_ptrs;
      logic rd_issue;     // read the two ring words
      logic ring_step;    // add, advance, write
      logic start_q;      // start divider on value / divisor
      logic set_result;   // latch result
      logic [1:0] res_status;
      logic res_zero;
      logic clr_attempts;
   } ctrl_type;

   typedef struct packed {
      logic div_busy;
      logic fill_last;
      logic over_retry;   // attempts exceeded limit on this step
      logic in_limit;     // last sum within limit
      logic small_size;
   } stat_type;
endpackage
`default_nettype wire

// ----- rtl/alrr_divider.sv -----
// Radix-2 restoring divider for 32-bit unsigned operands, one quotient bit per cycle.
// Depends on alrr_pkg.
`default_nettype none
module alrr_divider
   import alrr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             busy,
   output logic [31:0]      quotient
);
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] trial;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      trial  = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
         cnt_in = 6'd32;
      end else if (cnt_ff != 6'd0) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = (cnt_ff != 6'd0);
   assign quotient = quo_ff;
endmodule
`default_nettype wire

// ----- rtl/alrr_datapath.sv -----
// Datapath: ring memory, pointers, seed fill, adder, limit, counters and result register.
// Depends on alrr_pkg and alrr_divider.
`default_nettype none
module alrr_datapath
   import alrr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ctrl_type    ctrl,
   output stat_type         stat,
   input  wire logic        req_command,
   input  wire logic [31:0] req_size,
   input  wire logic [31:0] seed,
   output logic [31:0]      res_value,
   output logic [1:0]       res_status
);
   logic [31:0] ring_mem [RING_SIZE];
   logic [31:0] rd_a_ff, rd_b_ff;
   logic [5:0]  p1_ff, p1_in, p2_ff, p2_in, pw_ff, pw_in;
   logic [5:0]  fidx_ff;
   logic [31:0] fval_ff;
   logic [31:0] size_ff, divisor_ff, limit_ff, value_ff;
   logic [15:0] att_ff;
   logic        in_lim_ff;
   logic [31:0] res_v_ff;
   logic [1:0]  res_s_ff;
   logic [31:0] sum, div_a, div_b, div_q;
   logic [31:0] prod;
   logic        div_busy, size_le_one;

   function automatic logic [5:0] next_ptr(input logic [5:0] p);
      return (p == 6'(RING_SIZE - 1)) ? 6'd0 : p + 6'd1;
   endfunction

   assign size_le_one = (size_ff <= 32'd1);
   assign sum   = rd_a_ff + rd_b_ff;
   assign div_a = ctrl.start_lim ? WORD_MAX : value_ff;
   assign div_b = ctrl.start_lim ? size_ff : divisor_ff;
   assign prod  = size_ff * div_q;
   assign p1_in = next_ptr(p1_ff);
   assign p2_in = next_ptr(p2_ff);
   assign pw_in = next_ptr(pw_ff);

   alrr_divider u_div (
      .clock(clock), .reset(reset), .start(ctrl.start_lim | ctrl.start_q),
      .dividend(div_a), .divisor(div_b), .busy(div_busy), .quotient(div_q)
   );

   always_ff @(posedge clock) begin
      if (ctrl.fill_step) begin
         ring_mem[fidx_ff] <= fval_ff;
      end else if (ctrl.ring_step) begin
         ring_mem[pw_in] <= sum;
      end
      if (ctrl.rd_issue) begin
         rd_a_ff <= ring_mem[p1_ff];
         rd_b_ff <= ring_mem[p2_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff <= '0;
         p2_ff <= LAG_START;
         pw_ff <= WRITE_START;
      end else if (ctrl.reset_ptrs) begin
         p1_ff <= '0;
         p2_ff <= LAG_START;
         pw_ff <= WRITE_START;
      end else if (ctrl.ring_step) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         pw_ff <= pw_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_req) begin
         size_ff <= req_command ? WORD_MAX : req_size;
      end else if (ctrl.reset_ptrs) begin
         size_ff <= WORD_MAX;
      end
      if (ctrl.fill_init) begin
         fidx_ff <= '0;
         fval_ff <= seed;
      end else if (ctrl.fill_step) begin
         fidx_ff <= fidx_ff + 6'd1;
         fval_ff <= (fval_ff << 1) + fval_ff + SEED_ADD;
      end
      if (ctrl.start_lim) begin
         divisor_ff <= 32'd1;
      end else if (ctrl.calc_limit) begin
         divisor_ff <= size_le_one ? 32'd1 : div_q;
      end
      if (ctrl.calc_limit) begin
         limit_ff <= size_le_one ? WORD_MAX : prod - 32'd1;
      end
      if (ctrl.ring_step) begin
         value_ff  <= sum;
         in_lim_ff <= (sum <= limit_ff);
      end
      if (ctrl.clr_attempts) begin
         att_ff <= '0;
      end else if (ctrl.ring_step) begin
         att_ff <= att_ff + 16'd1;
      end
      if (ctrl.set_result) begin
         res_v_ff <= ctrl.res_zero ? 32'd0 : div_q;
         res_s_ff <= ctrl.res_status;
      end
   end

   assign stat.div_busy   = div_busy;
   assign stat.fill_last  = (fidx_ff == 6'(RING_SIZE - 1));
   assign stat.over_retry = (att_ff > RETRY_LIMIT);
   assign stat.in_limit   = in_lim_ff;
   assign stat.small_size = size_le_one;
   assign res_value       = res_v_ff;
   assign res_status      = res_s_ff;
endmodule
`default_nettype wire

// ----- rtl/alrr_controller.sv -----
// Controller state machine sequencing reseed, warmup, draws, retries and divisions.
// Depends on alrr_pkg.
`default_nettype none
module alrr_controller
   import alrr_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_fire,
   input  wire logic     req_command,
   input  wire stat_type stat,
   input  wire logic     rsp_free,
   output ctrl_type      ctrl,
   output logic          busy,
   output logic          rsp_load
);
   state_type   state_ff, state_in;
   logic        seeded_ff, seeded_in;
   logic        warm_ff, warm_in;
   logic [15:0] wcnt_ff, wcnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         seeded_ff <= 1'b0;
         warm_ff   <= 1'b0;
         wcnt_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         seeded_ff <= seeded_in;
         warm_ff   <= warm_in;
         wcnt_ff   <= wcnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      seeded_in = seeded_ff;
      warm_in   = warm_ff;
      wcnt_in   = wcnt_ff;
      ctrl      = '0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               ctrl.load_req = 1'b1;
               if (req_command == CMD_RESEED) begin
                  state_in = S_FILL;
                  ctrl.fill_init = 1'b1;
               end else if (!seeded_ff) begin
                  ctrl.set_result = 1'b1;
                  ctrl.res_zero   = 1'b1;
                  ctrl.res_status = ST_NOINIT;
                  state_in = S_DONE;
               end else begin
                  state_in = S_DIV_LIM;
               end
            end
         end
         S_FILL: begin
            ctrl.fill_step = 1'b1;
            if (stat.fill_last) begin
               ctrl.reset_ptrs = 1'b1;
               seeded_in = 1'b1;
               warm_in   = 1'b1;
               wcnt_in   = '0;
               state_in  = (WARMUP_DRAWS == 16'd0) ? S_DONE : S_DIV_LIM;
               if (WARMUP_DRAWS == 16'd0) begin
                  ctrl.set_result = 1'b1;
                  ctrl.res_zero   = 1'b1;
                  ctrl.res_status = ST_OK;
               end
            end
         end
         S_DIV_LIM: begin
            ctrl.start_lim = 1'b1;
            state_in = S_DIV_LIM_RUN;
         end
         S_DIV_LIM_RUN: begin
            if (!stat.div_busy) begin
               state_in = S_LIMIT;
            end
         end
         S_LIMIT: begin
            ctrl.calc_limit   = 1'b1;
            ctrl.clr_attempts = 1'b1;
            state_in = S_READ;
         end
         S_READ: begin
            ctrl.rd_issue = 1'b1;
            state_in = S_STEP;
         end
         S_STEP: begin
            ctrl.ring_step = 1'b1;
            state_in = S_DIV_Q;
         end
         S_DIV_Q: begin
            priority if (stat.over_retry) begin
               ctrl.res_zero   = 1'b1;
               ctrl.res_status = ST_RETRY;
               state_in = S_DIV_Q_RUN;
            end else if (!stat.small_size && !stat.in_limit) begin
               state_in = S_READ;
            end else begin
               ctrl.res_zero   = stat.small_size;
               ctrl.res_status = ST_OK;
               ctrl.start_q    = !stat.small_size;
               state_in = S_DIV_Q_RUN;
            end
         end
         S_DIV_Q_RUN: begin
            if (!stat.div_busy) begin
               if (warm_ff) begin
                  wcnt_in = wcnt_ff + 16'd1;
                  if (wcnt_ff + 16'd1 == WARMUP_DRAWS) begin
                     warm_in = 1'b0;
                     ctrl.set_result = 1'b1;
                     ctrl.res_zero   = 1'b1;
                     ctrl.res_status = ST_OK;
                     state_in = S_DONE;
                  end else begin
                     ctrl.clr_attempts = 1'b1;
                     state_in = S_READ;
                  end
               end else begin
                  ctrl.set_result = 1'b1;
                  ctrl.res_zero   = stat.over_retry || stat.small_size;
                  ctrl.res_status = stat.over_retry ? ST_RETRY : ST_OK;
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);
endmodule
`default_nettype wire

// ----- rtl/additive_lagged_random_range_unit.sv -----
// Top level of the additive lagged random range unit.
// Depends on alrr_pkg, alrr_controller, alrr_datapath and alrr_divider.
//
// The unit takes one request at a time. A draw runs a serial divide for the range divisor,
// a ring step (repeated for each rejected sum) and, for range sizes above one, a second
// serial divide for the quotient; range sizes of zero and one answer with a zero value
// instead of the second divide. A draw before any reseed answers with a zero value and
// the no-init status. A reseed fills the 56-word ring and then runs 10000 warmup draws.
// The response sits in an output register, so the next request may be taken while it waits.
`default_nettype none
module additive_lagged_random_range_unit
   import alrr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // range_size [31:0]
   input  wire logic        req_tuser,   // command [0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // random_value [31:0]
   output logic [1:0]       rsp_tuser,   // status [1:0]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);
   ctrl_type    ctrl;
   stat_type    stat;
   logic        busy, rsp_load, req_fire;
   logic [31:0] seed_ff, res_value, rdata_ff;
   logic [1:0]  res_status, rstat_ff;
   logic        rvalid_ff;

   assign req_tready = !busy;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            seed_ff <= csr_data;
         end
         if (rsp_load) begin
            rvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rvalid_ff <= 1'b0;
         end
      end
      if (rsp_load) begin
         rdata_ff <= res_value;
         rstat_ff <= res_status;
      end
   end

   alrr_controller u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .req_command(req_tuser),
      .stat(stat), .rsp_free(!rvalid_ff || rsp_tready),
      .ctrl(ctrl), .busy(busy), .rsp_load(rsp_load)
   );

   alrr_datapath u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat), .req_command(req_tuser),
      .req_size(req_tdata), .seed(seed_ff),
      .res_value(res_value), .res_status(res_status)
   );

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tuser  = rstat_ff;
endmodule
`default_nettype wire
